>>> src/assembler_number_literal_parser_unit_defines.svh
// Assertion macros for the number literal parser.
`ifndef ASSEMBLER_NUMBER_LITERAL_PARSER_UNIT_DEFINES_SVH
`define ASSEMBLER_NUMBER_LITERAL_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define ALNP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ALNP_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ALNP_ASSERT_RST(label, clk, rst_n, prop, msg)

`define ALNP_ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

>>> src/alnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alnp_pkg;

    localparam int LENGTH_LIMIT = 255;
    localparam int CNT_W        = 8;
    localparam int VAL_W        = 64;
    localparam int NUM_LANES    = 4;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [VAL_W-1:0] t_value;
    typedef logic [1:0]       t_lane;
    typedef logic [4:0]       t_digit;

    localparam t_lane LANE_BIN = 2'd0;
    localparam t_lane LANE_OCT = 2'd1;
    localparam t_lane LANE_DEC = 2'd2;
    localparam t_lane LANE_HEX = 2'd3;

    localparam t_digit DIGIT_NONE       = 5'd16;
    localparam t_digit DIGIT_UNDERSCORE = 5'd17;

    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_D    = 8'h64;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_H    = 8'h68;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_Q    = 8'h71;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_LOWER_Y    = 8'h79;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    typedef struct packed {
        logic  valid;
        t_lane lane;
    } t_lane_sel;

    function automatic t_count sat_inc(input t_count v);
        return (32'(v) >= LENGTH_LIMIT) ? t_count'(LENGTH_LIMIT) : t_count'(v + 1'b1);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c inside {[CH_UPPER_A:CH_UPPER_Z]}) ? 8'(c + CASE_OFFSET) : c;
    endfunction

    function automatic t_digit digit_of(input logic [7:0] c);
        logic [7:0] f;
        t_digit     d;
        f = fold_case(c);
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = t_digit'(c - CH_ZERO);
        end else if (f inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            d = t_digit'(f - CH_LOWER_A + 8'd10);
        end else if (c == CH_UNDERSCORE) begin
            d = DIGIT_UNDERSCORE;
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

    function automatic t_lane_sel letter_lane(input logic [7:0] c);
        t_lane_sel s;
        s = '{valid: 1'b1, lane: LANE_BIN};
        case (fold_case(c))
            CH_LOWER_Y:             s.lane = LANE_BIN;
            CH_LOWER_O, CH_LOWER_Q: s.lane = LANE_OCT;
            CH_LOWER_T:             s.lane = LANE_DEC;
            CH_LOWER_H, CH_LOWER_X: s.lane = LANE_HEX;
            default:                s.valid = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] lane_radix(input t_lane l);
        logic [4:0] r;
        case (l)
            LANE_BIN: r = 5'd2;
            LANE_OCT: r = 5'd8;
            LANE_DEC: r = 5'd10;
            default:  r = 5'd16;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/assembler_number_literal_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assembler_number_literal_parser_unit_defines.svh"

// Number literal parser: takes one source character per transaction (tuser high on the
// first character of a literal) and emits one result transaction at the character that
// ends the literal: the first body character that is not a hex digit or an underscore.
// Sign, '$' and 0-letter prefixes, base suffixes h/x, y, t, o/q and underscores are
// handled; binary, octal, decimal and hex values build up side by side and the base is
// picked at the terminator. One character is accepted every cycle unless the input is
// stalled; the result is registered and appears in the cycle after its terminator, held
// in an output register that stalls the input only while a result waits and the sink is
// not ready. Values wrap modulo 2^64; counts saturate at 255.
module assembler_number_literal_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] start_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // [63:0] value, [71:64] digit_count,
                                             // [79:72] consumed, [80] suffix_used
    output logic             m_axis_tuser    // [0] found
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_BODY
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic               r_zp, n_zp;
    alnp_pkg::t_lane_sel r_fb, n_fb;
    alnp_pkg::t_value   r_acc  [alnp_pkg::NUM_LANES];
    alnp_pkg::t_value   n_acc  [alnp_pkg::NUM_LANES];
    alnp_pkg::t_count   r_dc   [alnp_pkg::NUM_LANES];
    alnp_pkg::t_count   n_dc   [alnp_pkg::NUM_LANES];
    alnp_pkg::t_count   r_sp   [alnp_pkg::NUM_LANES];
    alnp_pkg::t_count   n_sp   [alnp_pkg::NUM_LANES];
    logic [alnp_pkg::NUM_LANES-1:0] r_stopped, n_stopped;
    alnp_pkg::t_count   r_cnt, n_cnt;

    logic               r_m_valid;
    logic               r_found, n_found;
    alnp_pkg::t_value   r_value, n_value;
    alnp_pkg::t_count   r_dcount, n_dcount;
    alnp_pkg::t_count   r_cons, n_cons;
    logic               r_sfx, n_sfx;
    logic               res_fire;
    logic               in_accept;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic               done;
        logic [7:0]         c;
        logic [7:0]         f;
        alnp_pkg::t_count   pos;
        alnp_pkg::t_digit   d;
        alnp_pkg::t_lane_sel ls;
        alnp_pkg::t_lane    lane;
        alnp_pkg::t_count   stop;
        alnp_pkg::t_count   n;
        alnp_pkg::t_value   a;
        alnp_pkg::t_value   m;

        c    = s_axis_tdata;
        f    = alnp_pkg::fold_case(c);
        done = 1'b0;
        pos  = '0;
        d    = alnp_pkg::digit_of(c);
        ls   = '0;
        lane = alnp_pkg::LANE_BIN;
        stop = '0;
        n    = '0;
        a    = '0;
        m    = '0;

        n_phase   = r_phase;
        n_neg     = r_neg;
        n_zp      = r_zp;
        n_fb      = r_fb;
        n_acc     = r_acc;
        n_dc      = r_dc;
        n_sp      = r_sp;
        n_stopped = r_stopped;
        n_cnt     = r_cnt;

        res_fire = 1'b0;
        n_found  = 1'b0;
        n_value  = '0;
        n_dcount = '0;
        n_cons   = '0;
        n_sfx    = 1'b0;

        if (in_accept) begin
            if (s_axis_tuser) begin
                n_phase   = PH_START;
                n_neg     = 1'b0;
                n_zp      = 1'b0;
                n_fb      = '0;
                n_cnt     = '0;
                n_stopped = '0;
                for (int i = 0; i < alnp_pkg::NUM_LANES; i++) begin
                    n_acc[i] = '0;
                    n_dc[i]  = '0;
                    n_sp[i]  = '0;
                end
            end else if (r_phase == PH_IDLE) begin
                done = 1'b1;
            end
            pos = n_cnt;

            if (!done && n_phase == PH_START) begin
                n_phase = PH_SIGNED;
                if (c == alnp_pkg::CH_MINUS) begin
                    n_neg = 1'b1;
                    n_cnt = alnp_pkg::sat_inc(pos);
                    done  = 1'b1;
                end
            end

            if (!done && n_phase == PH_SIGNED) begin
                n_phase = PH_BODY;
                if (c == alnp_pkg::CH_DOLLAR) begin
                    n_fb  = '{valid: 1'b1, lane: alnp_pkg::LANE_HEX};
                    n_cnt = alnp_pkg::sat_inc(pos);
                    done  = 1'b1;
                end else if (c == alnp_pkg::CH_ZERO) begin
                    n_zp    = 1'b1;
                    n_phase = PH_ZERO;
                    n_cnt   = alnp_pkg::sat_inc(pos);
                    done    = 1'b1;
                end
            end else if (!done && n_phase == PH_ZERO) begin
                ls = alnp_pkg::letter_lane(c);
                if (f == alnp_pkg::CH_LOWER_B) begin
                    ls = '{valid: 1'b1, lane: alnp_pkg::LANE_BIN};
                end else if (f == alnp_pkg::CH_LOWER_D) begin
                    ls = '{valid: 1'b1, lane: alnp_pkg::LANE_DEC};
                end
                n_phase = PH_BODY;
                if (ls.valid) begin
                    n_fb  = ls;
                    n_cnt = alnp_pkg::sat_inc(pos);
                    done  = 1'b1;
                end
            end

            if (!done) begin
                if (d == alnp_pkg::DIGIT_UNDERSCORE) begin
                    n_cnt = alnp_pkg::sat_inc(pos);
                end else if (d < alnp_pkg::DIGIT_NONE) begin
                    for (int i = 0; i < alnp_pkg::NUM_LANES; i++) begin
                        a = n_acc[i];
                        case (alnp_pkg::t_lane'(i))
                            alnp_pkg::LANE_BIN: m = {a[62:0], 1'b0};
                            alnp_pkg::LANE_OCT: m = {a[60:0], 3'b000};
                            alnp_pkg::LANE_DEC: m = {a[60:0], 3'b000} + {a[62:0], 1'b0};
                            default:            m = {a[59:0], 4'b0000};
                        endcase
                        if (!n_stopped[i]) begin
                            if (d < alnp_pkg::lane_radix(alnp_pkg::t_lane'(i))) begin
                                n_acc[i] = m + alnp_pkg::t_value'(d);
                                n_dc[i]  = alnp_pkg::sat_inc(n_dc[i]);
                            end else begin
                                n_stopped[i] = 1'b1;
                                n_sp[i]      = pos;
                            end
                        end
                    end
                    n_cnt = alnp_pkg::sat_inc(pos);
                end else begin
                    ls = alnp_pkg::letter_lane(c);
                    if (n_fb.valid) begin
                        lane = n_fb.lane;
                    end else if (ls.valid) begin
                        lane  = ls.lane;
                        n_sfx = 1'b1;
                    end else begin
                        lane = n_zp ? alnp_pkg::LANE_OCT : alnp_pkg::LANE_DEC;
                    end
                    stop = n_stopped[lane] ? n_sp[lane] : pos;
                    n    = n_dc[lane];
                    res_fire = 1'b1;
                    if (n != '0 || n_zp) begin
                        n_found  = 1'b1;
                        n_value  = n_neg ? alnp_pkg::t_value'(-n_acc[lane]) : n_acc[lane];
                        n_dcount = (n != '0) ? n : alnp_pkg::t_count'(1);
                        n_cons   = n_sfx ? alnp_pkg::sat_inc(stop) : stop;
                    end else begin
                        n_sfx = 1'b0;
                    end
                    n_phase   = PH_IDLE;
                    n_neg     = 1'b0;
                    n_zp      = 1'b0;
                    n_fb      = '0;
                    n_cnt     = '0;
                    n_stopped = '0;
                    for (int i = 0; i < alnp_pkg::NUM_LANES; i++) begin
                        n_acc[i] = '0;
                        n_dc[i]  = '0;
                        n_sp[i]  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_neg     <= 1'b0;
            r_zp      <= 1'b0;
            r_fb      <= '0;
            r_cnt     <= '0;
            r_stopped <= '0;
            for (int i = 0; i < alnp_pkg::NUM_LANES; i++) begin
                r_acc[i] <= '0;
                r_dc[i]  <= '0;
                r_sp[i]  <= '0;
            end
            r_m_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_zp      <= n_zp;
            r_fb      <= n_fb;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            r_acc     <= n_acc;
            r_dc      <= n_dc;
            r_sp      <= n_sp;
            if (res_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (res_fire) begin
            r_found  <= n_found;
            r_value  <= n_value;
            r_dcount <= n_dcount;
            r_cons   <= n_cons;
            r_sfx    <= n_sfx;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_found;
    assign m_axis_tdata  = {7'b0, r_sfx, r_cons, r_dcount, r_value};

    `ALNP_ASSERT_RST(a_not_found_zero, i_clk, i_rst_n,
        r_m_valid && !r_found |-> r_value == '0 && r_dcount == '0 && r_cons == '0 && !r_sfx,
        "not-found result carries nonzero fields")
    `ALNP_ASSERT_RST(a_found_has_count, i_clk, i_rst_n,
        r_m_valid && r_found |-> r_dcount != '0,
        "found result with zero digit count")
    `ALNP_ASSERT_RST(a_suffix_consumed, i_clk, i_rst_n,
        r_m_valid && r_sfx |-> r_found && r_cons != '0,
        "suffix taken without consumed characters")
    `ALNP_ASSERT_RST(a_idle_cleared, i_clk, i_rst_n,
        r_phase == PH_IDLE |-> r_cnt == '0 && !r_neg && !r_zp && !r_fb.valid && r_stopped == '0,
        "idle phase with literal state left over")

endmodule

`default_nettype wire

>>> tb/assembler_number_literal_parser_check.sv
`timescale 1ns / 1ps

module assembler_number_literal_parser_check
    import alnp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_char_valid,
    input  logic        i_char_ready,
    input  logic [7:0]  i_char_data,     // [7:0] char_code
    input  logic        i_char_start,    // [0] start_req
    input  logic        i_result_valid,
    input  logic        i_result_ready,
    input  logic [87:0] i_result_data,   // [63:0] value, [71:64] digit_count,
                                         // [79:72] consumed, [80] suffix_used
    input  logic        i_result_found,  // [0] found
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_START,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_BODY
    } t_scan_phase;

    typedef struct packed {
        logic   found;
        t_value value;
        t_count digits;
        t_count consumed;
        logic   suffix;
    } t_literal_result;

    t_scan_phase     scan_phase;
    logic            minus_seen;
    logic            lead_zero;
    logic            prefix_base_set;
    t_lane           prefix_lane;
    t_value          lane_value    [NUM_LANES];
    t_count          lane_digits   [NUM_LANES];
    t_count          lane_halt_pos [NUM_LANES];
    logic            lane_halted   [NUM_LANES];
    t_count          chars_seen;
    t_literal_result pending_literals [$];
    int              mismatch_count;

    function automatic t_count bump(input t_count v);
        return (int'(v) >= LENGTH_LIMIT) ? t_count'(LENGTH_LIMIT) : t_count'(v + 8'd1);
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
    endfunction

    function automatic t_digit char_digit(input logic [7:0] c);
        logic [7:0] f;
        f = lower(c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return t_digit'(c - CH_ZERO);
        end
        if (f >= CH_LOWER_A && f <= CH_LOWER_F) begin
            return t_digit'(f - CH_LOWER_A + 8'd10);
        end
        if (c == CH_UNDERSCORE) begin
            return DIGIT_UNDERSCORE;
        end
        return DIGIT_NONE;
    endfunction

    function automatic t_lane_sel base_letter(input logic [7:0] c);
        t_lane_sel sel;
        sel = '{valid: 1'b1, lane: LANE_BIN};
        case (lower(c))
            CH_LOWER_Y: begin
                sel.lane = LANE_BIN;
            end
            CH_LOWER_O, CH_LOWER_Q: begin
                sel.lane = LANE_OCT;
            end
            CH_LOWER_T: begin
                sel.lane = LANE_DEC;
            end
            CH_LOWER_H, CH_LOWER_X: begin
                sel.lane = LANE_HEX;
            end
            default: begin
                sel.valid = 1'b0;
            end
        endcase
        return sel;
    endfunction

    function automatic t_value lane_base(input t_lane l);
        case (l)
            LANE_BIN: begin
                return 64'd2;
            end
            LANE_OCT: begin
                return 64'd8;
            end
            LANE_DEC: begin
                return 64'd10;
            end
            default: begin
                return 64'd16;
            end
        endcase
    endfunction

    task automatic drop_literal();
        int i;
        minus_seen      = 1'b0;
        lead_zero       = 1'b0;
        prefix_base_set = 1'b0;
        prefix_lane     = LANE_BIN;
        chars_seen      = '0;
        for (i = 0; i < NUM_LANES; i++) begin
            lane_value[i]    = '0;
            lane_digits[i]   = '0;
            lane_halt_pos[i] = '0;
            lane_halted[i]   = 1'b0;
        end
    endtask

    task automatic scan_char(input logic [7:0] c, input logic start);
        t_lane_sel       sel;
        t_digit          d;
        t_count          pos;
        t_count          stop;
        t_count          n;
        t_lane           lane;
        logic            sfx;
        t_literal_result r;
        int              i;
        if (start) begin
            drop_literal();
            scan_phase = SCAN_START;
        end else if (scan_phase == SCAN_IDLE) begin
            return;
        end
        pos = chars_seen;

        if (scan_phase == SCAN_START) begin
            if (c == CH_MINUS) begin
                minus_seen = 1'b1;
                scan_phase = SCAN_SIGNED;
                chars_seen = bump(pos);
                return;
            end
            scan_phase = SCAN_SIGNED;
        end
        if (scan_phase == SCAN_SIGNED) begin
            if (c == CH_DOLLAR) begin
                prefix_base_set = 1'b1;
                prefix_lane     = LANE_HEX;
                scan_phase      = SCAN_BODY;
                chars_seen      = bump(pos);
                return;
            end
            if (c == CH_ZERO) begin
                lead_zero  = 1'b1;
                scan_phase = SCAN_ZERO;
                chars_seen = bump(pos);
                return;
            end
            scan_phase = SCAN_BODY;
        end else if (scan_phase == SCAN_ZERO) begin
            sel = base_letter(c);
            if (lower(c) == CH_LOWER_B) begin
                sel = '{valid: 1'b1, lane: LANE_BIN};
            end else if (lower(c) == CH_LOWER_D) begin
                sel = '{valid: 1'b1, lane: LANE_DEC};
            end
            scan_phase = SCAN_BODY;
            if (sel.valid) begin
                prefix_base_set = 1'b1;
                prefix_lane     = sel.lane;
                chars_seen      = bump(pos);
                return;
            end
        end

        d = char_digit(c);
        if (d == DIGIT_UNDERSCORE) begin
            chars_seen = bump(pos);
            return;
        end
        if (d < DIGIT_NONE) begin
            for (i = 0; i < NUM_LANES; i++) begin
                if (!lane_halted[i]) begin
                    if (t_value'(d) < lane_base(t_lane'(i))) begin
                        lane_value[i]  = lane_value[i] * lane_base(t_lane'(i)) + t_value'(d);
                        lane_digits[i] = bump(lane_digits[i]);
                    end else begin
                        lane_halted[i]   = 1'b1;
                        lane_halt_pos[i] = pos;
                    end
                end
            end
            chars_seen = bump(pos);
            return;
        end

        // terminator: settle the base and queue the answer
        sfx = 1'b0;
        if (prefix_base_set) begin
            lane = prefix_lane;
        end else begin
            sel = base_letter(c);
            if (sel.valid) begin
                lane = sel.lane;
                sfx  = 1'b1;
            end else begin
                lane = lead_zero ? LANE_OCT : LANE_DEC;
            end
        end
        stop = lane_halted[lane] ? lane_halt_pos[lane] : pos;
        n    = lane_digits[lane];
        r    = '0;
        if (n != 0 || lead_zero) begin
            r.found    = 1'b1;
            r.value    = minus_seen ? t_value'(0) - lane_value[lane] : lane_value[lane];
            r.digits   = (n != 0) ? n : t_count'(1);
            r.consumed = sfx ? bump(stop) : stop;
            r.suffix   = sfx;
        end
        pending_literals.push_back(r);
        drop_literal();
        scan_phase = SCAN_IDLE;
    endtask

    task automatic flag_field(input string name, input t_value want, input t_value got);
        mismatch_count++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_literal_result want;
        t_literal_result got;
        if (!i_rst_n) begin
            drop_literal();
            scan_phase = SCAN_IDLE;
            pending_literals.delete();
            mismatch_count = 0;
        end else begin
            if (i_char_valid && i_char_ready) begin
                scan_char(i_char_data, i_char_start);
            end
            if (i_result_valid && i_result_ready) begin
                got.found    = i_result_found;
                got.value    = i_result_data[63:0];
                got.digits   = i_result_data[71:64];
                got.consumed = i_result_data[79:72];
                got.suffix   = i_result_data[80];
                if (pending_literals.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none pending, expected nothing actual %0h",
                             $time, got);
                end else begin
                    want = pending_literals.pop_front();
                    if (got.found !== want.found) begin
                        flag_field("found", t_value'(want.found), t_value'(got.found));
                    end
                    if (got.value !== want.value) begin
                        flag_field("value", want.value, got.value);
                    end
                    if (got.digits !== want.digits) begin
                        flag_field("digit_count", t_value'(want.digits), t_value'(got.digits));
                    end
                    if (got.consumed !== want.consumed) begin
                        flag_field("consumed", t_value'(want.consumed), t_value'(got.consumed));
                    end
                    if (got.suffix !== want.suffix) begin
                        flag_field("suffix_used", t_value'(want.suffix), t_value'(got.suffix));
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_literals.size();
    end

endmodule

>>> tb/tb_assembler_number_literal_parser_unit.sv
`timescale 1ns / 1ps

module tb_assembler_number_literal_parser_unit;
    import alnp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int HOLD_AT_CYCLE  = 1200;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_text_char;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tuser  = 1'b0;    // [0] start_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;            // [63:0] value, [71:64] digit_count,
                                          // [79:72] consumed, [80] suffix_used
    logic        m_axis_tuser;            // [0] found

    int          mismatches;
    int          outstanding;
    int          stall_cycles = 0;
    int          long_literals = 0;
    t_text_char  source_text [$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    assembler_number_literal_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assembler_number_literal_parser_check literal_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (s_axis_tvalid),
        .i_char_ready   (s_axis_tready),
        .i_char_data    (s_axis_tdata),
        .i_char_start   (s_axis_tuser),
        .i_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .i_result_data  (m_axis_tdata),
        .i_result_found (m_axis_tuser),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    function automatic logic is_body_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) || (c == CH_UNDERSCORE);
    endfunction

    task automatic push_char(input logic [7:0] c, input logic first);
        t_text_char t;
        t.ch    = c;
        t.first = first;
        source_text.push_back(t);
    endtask

    task automatic push_text(input string s, input logic first);
        int i;
        for (i = 0; i < s.len(); i++) begin
            push_char(s[i], first && (i == 0));
        end
    endtask

    task automatic push_random_literal();
        string      prefix_letters;
        string      suffix_letters;
        int         len;
        int         pick;
        int         i;
        int         radix;
        logic [7:0] c;
        logic [7:0] d;
        logic       first;
        prefix_letters = "xXhHbByYdDtToOqQ";
        suffix_letters = "hHxXyYtToOqQ";
        first = 1'b1;
        if ($urandom_range(0, 1) == 1) begin
            push_char(CH_MINUS, first);
            first = 1'b0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            push_char(CH_DOLLAR, first);
            first = 1'b0;
        end else if (pick < 5) begin
            push_char(CH_ZERO, first);
            push_char(prefix_letters[$urandom_range(0, 15)], 1'b0);
            first = 1'b0;
        end else if (pick < 6) begin
            push_char(CH_ZERO, first);
            first = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2 && long_literals < 3) begin
            len = $urandom_range(256, 300);
            long_literals++;
        end else if (pick < 12) begin
            len = $urandom_range(11, 24);
        end else begin
            len = $urandom_range(0, 10);
        end
        case ($urandom_range(0, 3))
            0: begin
                radix = 2;
            end
            1: begin
                radix = 8;
            end
            2: begin
                radix = 10;
            end
            default: begin
                radix = 16;
            end
        endcase
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                c = CH_UNDERSCORE;
            end else begin
                d = (pick < 13) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, radix - 1));
                if (d < 8'd10) begin
                    c = CH_ZERO + d;
                end else begin
                    c = CH_LOWER_A + d - 8'd10 - (($urandom_range(0, 1) == 1) ? CASE_OFFSET : 8'd0);
                end
            end
            push_char(c, first);
            first = 1'b0;
        end
        pick = $urandom_range(0, 99);
        // leave the literal open so that the next start cuts it short
        if (pick < 10) begin
            return;
        end
        if (pick < 55) begin
            c = suffix_letters[$urandom_range(0, 11)];
        end else begin
            c = 8'($urandom_range(0, 255));
            while (is_body_char(c)) begin
                c = 8'($urandom_range(0, 255));
            end
        end
        push_char(c, first);
        if ($urandom_range(0, 19) == 0) begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++) begin
                push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("assembler_number_literal_parser_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int          cyc;
        int          hold;
        t_ready_mode mode;
        cyc  = 0;
        hold = 0;
        mode = READY_ALWAYS;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == HOLD_AT_CYCLE) begin
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                if (cyc % 96 == 0) begin
                    mode = t_ready_mode'($urandom_range(0, 3));
                end
                case (mode)
                    READY_ALWAYS: begin
                        m_axis_tready <= 1'b1;
                    end
                    READY_COIN: begin
                        m_axis_tready <= ($urandom_range(0, 1) == 1);
                    end
                    READY_SPARSE: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_axis_tready <= ((cyc % 7) < 3);
                    end
                endcase
            end
        end
    end

    initial begin
        int   idx;
        int   burst;
        int   gap;
        int   pause_at;
        int   directed;
        logic paused;
        logic offering;
        push_text("-$_g", 1'b1);
        push_text("0xFfh", 1'b1);
        push_char(8'hFF, 1'b0);
        push_text("12", 1'b1);
        push_text("101y", 1'b1);
        push_text("0", 1'b1);
        push_char(8'h00, 1'b0);
        push_text("19O", 1'b1);
        push_text("-7T", 1'b1);
        directed = source_text.size();
        while (source_text.size() < directed + RANDOM_ITEMS) begin
            push_random_literal();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pause_at = source_text.size() / 2;
        paused   = 1'b0;
        offering = 1'b0;
        idx      = 0;
        while (idx < source_text.size()) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            while (burst > 0 && idx < source_text.size()) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= source_text[idx].ch;
                s_axis_tuser  <= source_text[idx].first;
                offering = 1'b1;
                @(posedge i_clk);
                while (!s_axis_tready) begin
                    @(posedge i_clk);
                end
                @(negedge i_clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (!paused && idx >= pause_at) begin
                // drain every result before going on
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
                @(negedge i_clk);
                while (outstanding != 0) begin
                    @(negedge i_clk);
                end
            end else if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (offering) begin
            s_axis_tvalid <= 1'b0;
        end

        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("assembler_number_literal_parser_unit: match");
        end else begin
            $display("assembler_number_literal_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
